// File: rtl/sfd_pkg.sv
// Shared types, constants and helper functions of the sinc FIR decimator.
`default_nettype none
package sfd_pkg;

   // Default sizing of the filter.
   localparam int MAX_FACTOR_DEF = 1024;
   localparam int MAX_ORDER_DEF  = 3;

   // Fixed field widths.
   localparam int FACTOR_W = 11;
   localparam int ORDER_W  = 2;
   localparam int TAPS_W   = 12;
   localparam int NORM_W   = 31;
   localparam int WGT_W    = 32;
   localparam int ACC_W    = 128;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FACTOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER  = 1'b1;

   typedef struct packed {
      logic               action;
      logic [63:0]        sample_index;
      logic signed [63:0] sample_value;
      logic               sample_is_nan;
   } req_type;

   typedef struct packed {
      logic signed [63:0] filtered_value;
      logic               result_is_nan;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_SEED  = 2'd1,
      CMD_STORE = 2'd2,
      CMD_EMIT  = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [63:0]  value;
      logic         nan;
   } cmd_type;

   // Effective configuration seen by the front and back parts.
   typedef struct packed {
      logic [FACTOR_W-1:0] factor;
      logic [ORDER_W-1:0]  order;
      logic [TAPS_W-1:0]   taps;
      logic [NORM_W-1:0]   norm;
   } cfg_type;

   // Impulse of the N-th difference of the kernel at the start of box segment seg.
   function automatic logic signed [3:0] impulse_coef(input logic [1:0] order,
                                                      input logic [1:0] seg);
      logic signed [3:0] c;
      c = 4'sd0;
      case (order)
         2'd1: begin
            case (seg)
               2'd0:    c = 4'sd1;
               2'd1:    c = -4'sd1;
               default: c = 4'sd0;
            endcase
         end
         2'd2: begin
            case (seg)
               2'd0:    c = 4'sd1;
               2'd1:    c = -4'sd2;
               2'd2:    c = 4'sd1;
               default: c = 4'sd0;
            endcase
         end
         default: begin
            case (seg)
               2'd0:    c = 4'sd1;
               2'd1:    c = -4'sd3;
               2'd2:    c = 4'sd3;
               default: c = -4'sd1;
            endcase
         end
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// File: rtl/sfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sfd_ram #(
   parameter int WIDTH = 65,
   parameter int DEPTH = 3070
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// File: rtl/sfd_cmd_fifo.sv
// Two-entry command queue between the front and back parts.
`default_nettype none
module sfd_cmd_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire sfd_pkg::cmd_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output sfd_pkg::cmd_type      pop_data,
   output logic                  empty
);

   sfd_pkg::cmd_type mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/sfd_front.sv
// Front part: alignment, decimation phase and command classification.
`default_nettype none
module sfd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear_run,
   input  wire sfd_pkg::cfg_type cfg,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire sfd_pkg::req_type req_data,
   output logic                  cmd_push,
   output sfd_pkg::cmd_type      cmd_data,
   input  wire logic             fifo_full
);

   typedef enum logic [2:0] {
      F_IDLE   = 3'b001,
      F_MOD    = 3'b010,
      F_DECIDE = 3'b100
   } front_state_type;

   front_state_type state_ff;
   logic                          started_ff;
   logic [sfd_pkg::FACTOR_W-1:0]  phase_ff;
   logic [63:0]                   idx_ff;
   logic [sfd_pkg::FACTOR_W-1:0]  rem_ff;
   logic [5:0]                    bit_cnt_ff;
   logic [63:0]                   hold_value_ff;
   logic                          hold_nan_ff;

   logic                          accept;
   logic [sfd_pkg::FACTOR_W-1:0]  phase_in;
   logic [sfd_pkg::FACTOR_W:0]    trial;
   logic [sfd_pkg::FACTOR_W-1:0]  rem_in;

   assign req_full = (state_ff != F_IDLE) || fifo_full;
   assign accept   = req_push && !req_full;
   assign phase_in = phase_ff + sfd_pkg::FACTOR_W'(1);

   // One remainder bit per cycle of sample_index modulo the factor.
   always_comb begin
      trial = {rem_ff, idx_ff[63]};
      if (trial >= {1'b0, cfg.factor}) begin
         rem_in = sfd_pkg::FACTOR_W'(trial - {1'b0, cfg.factor});
      end else begin
         rem_in = trial[sfd_pkg::FACTOR_W-1:0];
      end
   end

   // Command built for the queue.
   always_comb begin
      cmd_push       = 1'b0;
      cmd_data.kind  = sfd_pkg::CMD_CLEAR;
      cmd_data.value = req_data.sample_value;
      cmd_data.nan   = req_data.sample_is_nan;
      unique case (state_ff)
         F_IDLE: begin
            if (accept && (req_data.action || started_ff)) begin
               cmd_push = 1'b1;
               if (req_data.action) begin
                  cmd_data.kind = sfd_pkg::CMD_CLEAR;
               end else if (phase_in == cfg.factor) begin
                  cmd_data.kind = sfd_pkg::CMD_EMIT;
               end else begin
                  cmd_data.kind = sfd_pkg::CMD_STORE;
               end
            end
         end
         F_DECIDE: begin
            cmd_data.kind  = sfd_pkg::CMD_SEED;
            cmd_data.value = hold_value_ff;
            cmd_data.nan   = hold_nan_ff;
            cmd_push       = (rem_ff == '0) && !fifo_full;
         end
         F_MOD: begin
         end
         default: begin
         end
      endcase
   end

   // Held sample and shift register for the alignment check.
   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && accept) begin
         hold_value_ff <= req_data.sample_value;
         hold_nan_ff   <= req_data.sample_is_nan;
         idx_ff        <= req_data.sample_index;
      end else if (state_ff == F_MOD) begin
         idx_ff <= {idx_ff[62:0], 1'b0};
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         started_ff <= 1'b0;
         phase_ff   <= '0;
         rem_ff     <= '0;
         bit_cnt_ff <= '0;
      end else if (clear_run) begin
         state_ff   <= F_IDLE;
         started_ff <= 1'b0;
         phase_ff   <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  if (req_data.action) begin
                     started_ff <= 1'b0;
                     phase_ff   <= '0;
                  end else if (started_ff) begin
                     phase_ff <= (phase_in == cfg.factor) ? '0 : phase_in;
                  end else begin
                     rem_ff     <= '0;
                     bit_cnt_ff <= '0;
                     state_ff   <= F_MOD;
                  end
               end
            end
            F_MOD: begin
               rem_ff     <= rem_in;
               bit_cnt_ff <= bit_cnt_ff + 6'd1;
               if (bit_cnt_ff == 6'd63) begin
                  state_ff <= F_DECIDE;
               end
            end
            F_DECIDE: begin
               if (rem_ff != '0) begin
                  state_ff <= F_IDLE;
               end else if (!fifo_full) begin
                  started_ff <= 1'b1;
                  phase_ff   <= sfd_pkg::FACTOR_W'(1);
                  state_ff   <= F_IDLE;
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// File: rtl/sfd_div.sv
// Bit-serial divider of the rounded magnitude by the normaliser.
`default_nettype none
module sfd_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [sfd_pkg::ACC_W-1:0]   dividend,
   input  wire logic [sfd_pkg::NORM_W-1:0]  divisor,
   output logic                             done,
   output logic [63:0]                      quotient
);

   logic                        busy_ff;
   logic                        done_ff;
   logic [5:0]                  cnt_ff;
   logic [sfd_pkg::NORM_W-1:0]  rem_ff;
   logic [63:0]                 q_ff;
   logic [sfd_pkg::NORM_W:0]    trial;
   logic [sfd_pkg::NORM_W:0]    dext;

   assign done     = done_ff;
   assign quotient = q_ff;
   assign trial    = {rem_ff, q_ff[63]};
   assign dext     = {1'b0, divisor};

   // Upper half is below the divisor, so it seeds the remainder and 64 steps follow.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[64 +: sfd_pkg::NORM_W];
         q_ff   <= dividend[63:0];
      end else if (busy_ff) begin
         if (trial >= dext) begin
            rem_ff <= sfd_pkg::NORM_W'(trial - dext);
            q_ff   <= {q_ff[62:0], 1'b1};
         end else begin
            rem_ff <= trial[sfd_pkg::NORM_W-1:0];
            q_ff   <= {q_ff[62:0], 1'b0};
         end
      end
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/sfd_back.sv
// Back part: history ring, kernel weight generator, MAC sweep, rounding and output.
`default_nettype none
module sfd_back #(
   parameter int MAX_FACTOR = sfd_pkg::MAX_FACTOR_DEF,
   parameter int MAX_ORDER  = sfd_pkg::MAX_ORDER_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear_run,
   input  wire sfd_pkg::cfg_type cfg,
   input  wire logic             cmd_avail,
   input  wire sfd_pkg::cmd_type cmd_data,
   output logic                  cmd_pop,
   input  wire logic             rsp_pop,
   output logic                  rsp_empty,
   output sfd_pkg::rsp_type      rsp_data
);

   localparam int RING_DEPTH = MAX_ORDER * (MAX_FACTOR - 1) + 1;
   localparam int ADDR_W     = $clog2(RING_DEPTH);
   localparam int TW         = sfd_pkg::TAPS_W;
   localparam int AW         = sfd_pkg::ACC_W;
   localparam int WW         = sfd_pkg::WGT_W;

   typedef enum logic [6:0] {
      B_IDLE  = 7'b0000001,
      B_SWEEP = 7'b0000010,
      B_DRAIN = 7'b0000100,
      B_SUM   = 7'b0001000,
      B_MAG   = 7'b0010000,
      B_DIV   = 7'b0100000,
      B_OUT   = 7'b1000000
   } back_state_type;

   back_state_type state_ff;
   logic [TW-1:0]   wr_pos_ff;
   logic [TW-1:0]   filled_ff;
   logic [64:0]     seed_ff;
   logic [TW-1:0]   k_ff;
   logic [TW-1:0]   idx_ff;
   logic [sfd_pkg::FACTOR_W-1:0] cnt_ff;
   logic [1:0]      seg_ff;
   logic signed [WW-1:0] a1_ff, a2_ff, a3_ff;
   logic [WW-1:0]   w1_ff;
   logic            sel1_ff;
   logic            v1_ff;
   logic            v2_ff;
   logic [63:0]     plo_ff;
   logic signed [64:0] phi_ff;
   logic            nan_acc_ff;
   logic [AW-1:0]   acc_lo_ff;
   logic [AW-1:0]   acc_hi_ff;
   logic [AW-1:0]   total_ff;
   logic            neg_ff;
   logic            rsp_valid_ff;
   sfd_pkg::rsp_type rsp_ff;

   logic            do_write;
   logic [TW-1:0]   wa;
   logic [TW-1:0]   wr_pos_in;
   logic [TW-1:0]   filled_in;
   logic [TW-1:0]   idx_in;
   logic [64:0]     rd_data;
   logic [64:0]     tap;
   logic signed [WW-1:0] imp;
   logic signed [WW-1:0] a1_in, a2_in, a3_in;
   logic signed [WW-1:0] wsel;
   logic [63:0]     plo_in;
   logic signed [64:0] phi_in;
   logic            neg_c;
   logic [AW-1:0]   mag_c;
   logic            div_start;
   logic            div_done;
   logic [63:0]     quotient;
   logic            out_load;

   // Command intake and ring writes.
   assign cmd_pop  = (state_ff == B_IDLE) && cmd_avail;
   assign do_write = cmd_pop && (cmd_data.kind != sfd_pkg::CMD_CLEAR);
   assign wa       = (cmd_data.kind == sfd_pkg::CMD_SEED) ? '0 : wr_pos_ff;
   assign wr_pos_in = (wa + TW'(1) == cfg.taps) ? '0 : wa + TW'(1);

   always_comb begin
      if (cmd_data.kind == sfd_pkg::CMD_SEED) begin
         filled_in = TW'(1);
      end else if (filled_ff == cfg.taps) begin
         filled_in = filled_ff;
      end else begin
         filled_in = filled_ff + TW'(1);
      end
   end

   assign idx_in = (idx_ff + TW'(1) == cfg.taps) ? '0 : idx_ff + TW'(1);

   sfd_ram #(
      .WIDTH (65),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (wa[ADDR_W-1:0]),
      .wr_data ({cmd_data.nan, cmd_data.value}),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Kernel weight from integrating the N-th difference impulses.
   always_comb begin
      imp   = (cnt_ff == '0) ? WW'(sfd_pkg::impulse_coef(cfg.order, seg_ff)) : '0;
      a1_in = a1_ff + imp;
      a2_in = a2_ff + a1_in;
      a3_in = a3_ff + a2_in;
      case (cfg.order)
         2'd1:    wsel = a1_in;
         2'd2:    wsel = a2_in;
         default: wsel = a3_in;
      endcase
   end

   // Products of one tap; entries not written since start read as the seed.
   assign tap    = sel1_ff ? seed_ff : rd_data;
   assign plo_in = w1_ff * tap[31:0];
   assign phi_in = $signed({1'b0, w1_ff}) * $signed(tap[63:32]);

   // Rounding: magnitude plus half the normaliser.
   assign neg_c = total_ff[AW-1];
   assign mag_c = (neg_c ? ~total_ff : total_ff) + {98'b0, cfg.norm[sfd_pkg::NORM_W-1:1]}
                  + {127'b0, neg_c};
   assign div_start = (state_ff == B_MAG);

   sfd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_c),
      .divisor  (cfg.norm),
      .done     (div_done),
      .quotient (quotient)
   );

   assign out_load  = (state_ff == B_OUT) && (!rsp_valid_ff || rsp_pop);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (do_write && cmd_data.kind == sfd_pkg::CMD_SEED) begin
         seed_ff <= {cmd_data.nan, cmd_data.value};
      end
      if (state_ff == B_SWEEP) begin
         w1_ff   <= wsel;
         sel1_ff <= (idx_ff >= filled_ff);
         a1_ff   <= a1_in;
         a2_ff   <= a2_in;
         a3_ff   <= a3_in;
         idx_ff  <= idx_in;
         k_ff    <= k_ff + TW'(1);
         if (cnt_ff == cfg.factor - sfd_pkg::FACTOR_W'(1)) begin
            cnt_ff <= '0;
            seg_ff <= (seg_ff == 2'd3) ? seg_ff : seg_ff + 2'd1;
         end else begin
            cnt_ff <= cnt_ff + sfd_pkg::FACTOR_W'(1);
         end
      end else if (cmd_pop) begin
         idx_ff <= wr_pos_in;
         k_ff   <= '0;
         cnt_ff <= '0;
         seg_ff <= '0;
         a1_ff  <= '0;
         a2_ff  <= '0;
         a3_ff  <= '0;
      end
      if (v1_ff) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (cmd_pop) begin
         acc_lo_ff  <= '0;
         acc_hi_ff  <= '0;
         nan_acc_ff <= 1'b0;
      end else begin
         if (v1_ff) begin
            nan_acc_ff <= nan_acc_ff | tap[64];
         end
         if (v2_ff) begin
            acc_lo_ff <= acc_lo_ff + {64'b0, plo_ff};
            acc_hi_ff <= acc_hi_ff + {{63{phi_ff[64]}}, phi_ff};
         end
      end
      if (state_ff == B_SUM) begin
         total_ff <= {acc_hi_ff[95:0], 32'b0} + acc_lo_ff;
      end
      if (state_ff == B_MAG) begin
         neg_ff <= neg_c;
      end
      if (out_load) begin
         if (nan_acc_ff) begin
            rsp_ff.filtered_value <= '0;
            rsp_ff.result_is_nan  <= 1'b1;
         end else begin
            rsp_ff.filtered_value <= neg_ff ? 64'd0 - quotient : quotient;
            rsp_ff.result_is_nan  <= 1'b0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         wr_pos_ff    <= '0;
         filled_ff    <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= (state_ff == B_SWEEP);
         v2_ff <= v1_ff;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         if (clear_run) begin
            wr_pos_ff <= '0;
            filled_ff <= '0;
         end else if (cmd_pop && cmd_data.kind == sfd_pkg::CMD_CLEAR) begin
            wr_pos_ff <= '0;
            filled_ff <= '0;
         end else if (do_write) begin
            wr_pos_ff <= wr_pos_in;
            filled_ff <= filled_in;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (cmd_pop && cmd_data.kind == sfd_pkg::CMD_EMIT) begin
                  state_ff <= B_SWEEP;
               end
            end
            B_SWEEP: begin
               if (k_ff == cfg.taps - TW'(1)) begin
                  state_ff <= B_DRAIN;
               end
            end
            B_DRAIN: begin
               if (!v1_ff && !v2_ff) begin
                  state_ff <= B_SUM;
               end
            end
            B_SUM: state_ff <= B_MAG;
            B_MAG: state_ff <= B_DIV;
            B_DIV: begin
               if (div_done) begin
                  state_ff <= B_OUT;
               end
            end
            B_OUT: begin
               if (out_load) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// File: rtl/sinc_fir_decimator_core.sv
// Top level of the sinc FIR decimator: registers, front, command queue and back.
//
//   Channel  Ports                          Transfer when
//   input    req_push req_full req_data     req_push && !req_full
//   result   rsp_pop rsp_empty rsp_data     rsp_pop && !rsp_empty
//   config   csr_we csr_index csr_wdata     csr_we
//
// A stored sample is classified by the front and written to the ring by the back.
// Every R-th sample the back sweeps the ring with one MAC per tap (N*(R-1)+1
// taps), then rounds the sum and divides it bit-serially by the normaliser.
// Until aligned, the front checks each sample's index bit-serially and takes no new sample meanwhile.
// Reset is synchronous; it clears all control state and sets R = 2, N = 1.
// The front keeps taking samples while the back sweeps, until the queue fills.
`default_nettype none
module sinc_fir_decimator_core #(
   parameter int MAX_FACTOR = sfd_pkg::MAX_FACTOR_DEF,
   parameter int MAX_ORDER  = sfd_pkg::MAX_ORDER_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire sfd_pkg::req_type                 req_data,
   input  wire logic                             rsp_pop,
   output logic                                  rsp_empty,
   output sfd_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [sfd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sfd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int FW = sfd_pkg::FACTOR_W;

   logic [FW-1:0]               factor_ff;
   logic [sfd_pkg::ORDER_W-1:0] order_ff;
   logic [2*FW-1:0]             r2_ff;
   logic [sfd_pkg::NORM_W-1:0]  r3_ff;
   logic [FW-1:0]               r_eff;
   logic [sfd_pkg::ORDER_W-1:0] n_eff;
   logic [FW-1:0]               rm1;
   logic [3*FW-1:0]             r3_in;
   sfd_pkg::cfg_type            cfg;
   logic                        clear_run;
   logic                        cmd_push;
   sfd_pkg::cmd_type            cmd_in;
   sfd_pkg::cmd_type            cmd_out;
   logic                        fifo_full;
   logic                        fifo_empty;
   logic                        cmd_pop;

   // Configuration registers; any write restarts alignment.
   assign clear_run = csr_we;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FW'(2);
         order_ff  <= 2'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            sfd_pkg::CSR_FACTOR: factor_ff <= csr_wdata;
            sfd_pkg::CSR_ORDER:  order_ff  <= csr_wdata[sfd_pkg::ORDER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective factor and order, clamped to the supported range.
   always_comb begin
      if (factor_ff < FW'(2)) begin
         r_eff = FW'(2);
      end else if (factor_ff > FW'(MAX_FACTOR)) begin
         r_eff = FW'(MAX_FACTOR);
      end else begin
         r_eff = factor_ff;
      end
      if (order_ff == 2'd0) begin
         n_eff = 2'd1;
      end else if (order_ff > sfd_pkg::ORDER_W'(MAX_ORDER)) begin
         n_eff = sfd_pkg::ORDER_W'(MAX_ORDER);
      end else begin
         n_eff = order_ff;
      end
   end

   // Powers of R for the normaliser, one multiply per register.
   assign r3_in = r2_ff * r_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r2_ff <= (2*FW)'(4);
         r3_ff <= sfd_pkg::NORM_W'(8);
      end else begin
         r2_ff <= r_eff * r_eff;
         r3_ff <= r3_in[sfd_pkg::NORM_W-1:0];
      end
   end

   assign rm1 = r_eff - FW'(1);

   always_comb begin
      cfg.factor = r_eff;
      cfg.order  = n_eff;
      case (n_eff)
         2'd1: begin
            cfg.taps = sfd_pkg::TAPS_W'(rm1) + sfd_pkg::TAPS_W'(1);
            cfg.norm = sfd_pkg::NORM_W'(r_eff);
         end
         2'd2: begin
            cfg.taps = (sfd_pkg::TAPS_W'(rm1) << 1) + sfd_pkg::TAPS_W'(1);
            cfg.norm = sfd_pkg::NORM_W'(r2_ff);
         end
         default: begin
            cfg.taps = (sfd_pkg::TAPS_W'(rm1) << 1) + sfd_pkg::TAPS_W'(rm1)
                       + sfd_pkg::TAPS_W'(1);
            cfg.norm = r3_ff;
         end
      endcase
   end

   sfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .clear_run (clear_run),
      .cfg       (cfg),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in),
      .fifo_full (fifo_full)
   );

   sfd_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (fifo_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (fifo_empty)
   );

   sfd_back #(
      .MAX_FACTOR (MAX_FACTOR),
      .MAX_ORDER  (MAX_ORDER)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .clear_run (clear_run),
      .cfg       (cfg),
      .cmd_avail (!fifo_empty),
      .cmd_data  (cmd_out),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // The front never pushes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !fifo_full)
      else $error("command pushed into full queue");

   // The back never takes from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !fifo_empty)
      else $error("command taken from empty queue");

   // A clear transfer lands in the queue at once.
   a_clear_queued: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_data.action) |=> !fifo_empty)
      else $error("clear transfer not queued");
`endif

endmodule
`default_nettype wire

// File: tb/tb_sinc_fir_decimator_core.sv
// Self-checking testbench for the sinc FIR decimator core with its own predictor.
`default_nettype none
module tb_sinc_fir_decimator_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING = sfd_pkg::MAX_ORDER_DEF * (sfd_pkg::MAX_FACTOR_DEF - 1) + 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   sfd_pkg::req_type req_data = '0;
   logic rsp_pop = 1'b0;
   logic rsp_empty;
   sfd_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [sfd_pkg::CSR_IDX_W-1:0] csr_index = sfd_pkg::CSR_FACTOR;
   logic [sfd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   sinc_fir_decimator_core u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Filter state mirrored by the predictor.
   logic [63:0] hist_value[RING];
   bit hist_nan[RING];
   longint unsigned box_weight[RING];
   longint unsigned weight_tmp[RING];
   int unsigned cfg_factor = 2, cfg_order = 1;
   int unsigned box_len, tap_count, wr_pos, dec_phase;
   bit aligned;
   longint unsigned divisor;

   sfd_pkg::req_type pending_samples[$];
   sfd_pkg::rsp_type expected_outputs[$];
   int errors = 0;

   // Rebuilds the kernel by repeated box convolution and resets alignment.
   function automatic void rebuild_kernel();
      int unsigned r, n, len;
      longint unsigned acc;
      r = (cfg_factor < 2) ? 2 : (cfg_factor > 1024) ? 1024 : cfg_factor;
      n = (cfg_order < 1) ? 1 : (cfg_order > 3) ? 3 : cfg_order;
      box_len = r;
      tap_count = n * (r - 1) + 1;
      for (int i = 0; i < RING; i++) box_weight[i] = (i < r) ? 1 : 0;
      divisor = r;
      len = r;
      for (int o = 1; o < n; o++) begin
         acc = 0;
         for (int i = 0; i < len + r - 1; i++) begin
            if (i < len) acc += box_weight[i];
            if (i >= r) acc -= box_weight[i - r];
            weight_tmp[i] = acc;
         end
         for (int i = 0; i < len + r - 1; i++) box_weight[i] = weight_tmp[i];
         len += r - 1;
         divisor *= r;
      end
      aligned = 0;
      wr_pos = 0;
      dec_phase = 0;
   endfunction

   // Applies one accepted sample and queues the decimated output when one is due.
   function automatic void predict_sample(sfd_pkg::req_type s);
      logic signed [127:0] acc, sv, wv, mag, q;
      int unsigned idx;
      sfd_pkg::rsp_type o;
      bit any_nan;
      if (s.action) begin
         aligned = 0;
         wr_pos = 0;
         dec_phase = 0;
         return;
      end
      if (!aligned) begin
         if ((s.sample_index % box_len) != 0) return;
         for (int k = 0; k < tap_count; k++) begin
            hist_value[k] = s.sample_value;
            hist_nan[k] = s.sample_is_nan;
         end
         wr_pos = 0;
         aligned = 1;
      end
      hist_value[wr_pos] = s.sample_value;
      hist_nan[wr_pos] = s.sample_is_nan;
      wr_pos = (wr_pos + 1 >= tap_count) ? 0 : wr_pos + 1;
      dec_phase++;
      if (dec_phase < box_len) return;
      dec_phase = 0;
      acc = 0;
      any_nan = 0;
      idx = wr_pos;
      for (int k = 0; k < tap_count; k++) begin
         if (hist_nan[idx]) any_nan = 1;
         sv = $signed(hist_value[idx]);
         wv = $signed({64'd0, box_weight[k]});
         acc += sv * wv;
         idx = (idx + 1 >= tap_count) ? 0 : idx + 1;
      end
      if (any_nan) begin
         o.filtered_value = '0;
         o.result_is_nan = 1'b1;
      end else begin
         mag = (acc < 0) ? -acc : acc;
         q = (mag + $signed({64'd0, divisor / 2})) / $signed({64'd0, divisor});
         o.filtered_value = (acc < 0) ? -q[63:0] : q[63:0];
         o.result_is_nan = 1'b0;
      end
      expected_outputs.push_back(o);
   endfunction

   // Sender: bursts of transfers separated by random gaps.
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      bit drive;
      drive = 0;
      if (!reset) begin
         if (req_push && !req_full) begin
            predict_sample(pending_samples.pop_front());
         end
         if (req_push && req_full) begin
            drive = 1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (pending_samples.size() > 0) begin
            drive = 1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            end
         end
      end
      req_push <= drive;
      if (drive) req_data <= pending_samples[0];
   end

   // Receiver: stall pattern that cycles through free, random and periodic modes.
   int unsigned pop_cycle = 0;
   always @(posedge clock) begin
      sfd_pkg::rsp_type want;
      pop_cycle++;
      if (rsp_pop && !rsp_empty) begin
         if (expected_outputs.size() == 0) begin
            errors++;
            $display("%0t: unexpected output transfer value=%0d nan=%0b", $time,
                     rsp_data.filtered_value, rsp_data.result_is_nan);
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_data.filtered_value !== want.filtered_value) begin
               errors++;
               $display("%0t: filtered_value expected %0d actual %0d", $time,
                        want.filtered_value, rsp_data.filtered_value);
            end
            if (rsp_data.result_is_nan !== want.result_is_nan) begin
               errors++;
               $display("%0t: result_is_nan expected %0b actual %0b", $time,
                        want.result_is_nan, rsp_data.result_is_nan);
            end
         end
      end
      case ((pop_cycle / 300) % 3)
         0: rsp_pop <= 1'b1;
         1: rsp_pop <= ($urandom_range(0, 1) == 1);
         default: rsp_pop <= ((pop_cycle % 23) < 5);
      endcase
   end

   // Writes one register and mirrors it in the predictor.
   task automatic write_reg(input logic [sfd_pkg::CSR_IDX_W-1:0] idx,
                            input int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[sfd_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == sfd_pkg::CSR_FACTOR) cfg_factor = val & 32'h7FF;
      else cfg_order = val & 32'h3;
      rebuild_kernel();
   endtask

   // Waits for every sample to be taken and every output to arrive, then lets the core settle.
   task automatic drain();
      while (pending_samples.size() > 0 || req_push || expected_outputs.size() > 0)
         @(posedge clock);
      repeat (4000) @(posedge clock);
   endtask

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 6))
         0: return 64'h7FFF_FFFF_FFFF_FFFF;
         1: return 64'h8000_0000_0000_0000;
         2: return 64'($signed($urandom_range(0, 8)) - 4);
         3: return {{32{1'b0}}, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Queues a run of samples on a running index, with occasional clears, NaNs and jumps.
   task automatic load_run(input int count, input logic [63:0] first_index);
      sfd_pkg::req_type s;
      logic [63:0] run_index;
      run_index = first_index;
      for (int i = 0; i < count; i++) begin
         s.action = ($urandom_range(0, 59) == 0);
         s.sample_index = ($urandom_range(0, 79) == 0) ? {$urandom, $urandom} : run_index;
         s.sample_value = pick_value();
         s.sample_is_nan = ($urandom_range(0, 39) == 0);
         pending_samples.push_back(s);
         run_index++;
      end
   endtask

   function automatic sfd_pkg::req_type make_sample(logic act, logic [63:0] id,
                                                    logic [63:0] v, logic nan);
      sfd_pkg::req_type s;
      s.action = act;
      s.sample_index = id;
      s.sample_value = v;
      s.sample_is_nan = nan;
      return s;
   endfunction

   initial begin
      rebuild_kernel();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed samples at R = 2, N = 1: extremes, rounding, NaN, clear and alignment.
      pending_samples.push_back(make_sample(0, 64'd1, 64'd5, 0));
      pending_samples.push_back(make_sample(0, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 0));
      pending_samples.push_back(make_sample(0, 64'd1, 64'h7FFF_FFFF_FFFF_FFFF, 0));
      pending_samples.push_back(make_sample(0, 64'd2, 64'h8000_0000_0000_0000, 0));
      pending_samples.push_back(make_sample(0, 64'd3, 64'h8000_0000_0000_0000, 0));
      pending_samples.push_back(make_sample(0, 64'd4, 64'hFFFF_FFFF_FFFF_FFFF, 0));
      pending_samples.push_back(make_sample(0, 64'd5, 64'd0, 0));
      pending_samples.push_back(make_sample(0, 64'd6, 64'd1, 0));
      pending_samples.push_back(make_sample(0, 64'd7, 64'd0, 0));
      pending_samples.push_back(make_sample(0, 64'd8, 64'd3, 1));
      pending_samples.push_back(make_sample(0, 64'd9, 64'd3, 0));
      pending_samples.push_back(make_sample(0, 64'd10, 64'd7, 0));
      pending_samples.push_back(make_sample(1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd9, 1));
      pending_samples.push_back(make_sample(0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 0));
      pending_samples.push_back(make_sample(0, 64'hFFFF_FFFF_FFFF_FFFE, 64'd2, 0));
      pending_samples.push_back(make_sample(0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFD, 0));
      pending_samples.push_back(make_sample(0, 64'd1, 64'h1234_5678_9ABC_DEF0, 1));
      pending_samples.push_back(make_sample(0, 64'd2, 64'h0, 0));
      drain();

      // Random runs under a range of settings, the out-of-range ones included.
      write_reg(sfd_pkg::CSR_FACTOR, 3);
      write_reg(sfd_pkg::CSR_ORDER, 2);
      load_run(50, {$urandom, $urandom});
      drain();
      load_run(50, {$urandom, $urandom});
      drain();
      write_reg(sfd_pkg::CSR_FACTOR, 0);
      write_reg(sfd_pkg::CSR_ORDER, 0);
      load_run(80, {$urandom, $urandom});
      drain();
      write_reg(sfd_pkg::CSR_FACTOR, 5);
      write_reg(sfd_pkg::CSR_ORDER, 3);
      load_run(120, {$urandom, $urandom});
      drain();
      write_reg(sfd_pkg::CSR_FACTOR, 1);
      load_run(50, {$urandom, $urandom});
      drain();
      write_reg(sfd_pkg::CSR_FACTOR, 17);
      write_reg(sfd_pkg::CSR_ORDER, 2);
      load_run(100, {32'd0, $urandom});
      drain();
      write_reg(sfd_pkg::CSR_FACTOR, 4);
      write_reg(sfd_pkg::CSR_ORDER, 1);
      load_run(80, {$urandom, $urandom});
      drain();

      // Wide window: R = 300 at third order gives 898 taps.
      write_reg(sfd_pkg::CSR_FACTOR, 300);
      write_reg(sfd_pkg::CSR_ORDER, 3);
      for (int i = 0; i < 320; i++)
         pending_samples.push_back(make_sample(0, 64'(i), pick_value(), 0));
      drain();

      if (errors == 0) begin
         $display("tb_sinc_fir_decimator_core passed");
      end else begin
         $display("tb_sinc_fir_decimator_core failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #20_000_000;
      $display("tb_sinc_fir_decimator_core failed");
      $finish;
   end
endmodule
`default_nettype wire
